@@ hdl/stack_machine_hash_alu_macros.svh @@
// Assertion macros shared by the stack machine block.
`ifndef STACK_MACHINE_HASH_ALU_MACROS_SVH
`define STACK_MACHINE_HASH_ALU_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define SMH_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define SMH_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/smh_pkg.sv @@
// Shared types, codes and constants of the stack machine block.
package smh_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned WORD_W          = 32;
	localparam int unsigned DEPTH_OUT_W     = 5;
	localparam int unsigned S_TDATA_W       = 40;
	localparam int unsigned M_TDATA_W       = 72;
	localparam int unsigned QUEUE_DEPTH     = 2;
	localparam int unsigned QPTR_W          = 1;
	localparam int unsigned QCNT_W          = 2;

	typedef enum logic [2:0] {
		OP_PUSH     = 3'd0,
		OP_ADD      = 3'd1,
		OP_SHL      = 3'd2,
		OP_SHR      = 3'd3,
		OP_XOR      = 3'd4,
		OP_TO_MEM   = 3'd5,
		OP_PUSH_MEM = 3'd6,
		OP_BAD      = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_FEW      = 3'd2,
		ST_BADOP    = 3'd3,
		ST_SKIP     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CL_PUSH_IMM,
		CL_PUSH_MEM,
		CL_BINARY,
		CL_TO_MEM,
		CL_BAD
	} iclass_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SHL,
		ALU_SHR,
		ALU_XOR
	} alu_op_t;

	typedef struct packed {
		iclass_t             iclass;
		alu_op_t             alu_op;
		logic [WORD_W-1:0]   immediate;
		logic                last;
	} instr_t;

	typedef struct packed {
		logic   valid;
		instr_t instr;
	} q_head_t;

endpackage

@@ hdl/smh_front.sv @@
// Front end: accepts input words, decodes them and queues them for execution.
module smh_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// Fields from bit 0: opcode[2:0], immediate[34:3], zero fill[39:35].
	input  logic [smh_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	input  logic                             s_axis_tlast,
	output smh_pkg::q_head_t                 head,
	input  logic                             pop
);

	localparam logic [smh_pkg::QCNT_W-1:0] QFULL = smh_pkg::QCNT_W'(smh_pkg::QUEUE_DEPTH);

	smh_pkg::instr_t                 q_mem_q [smh_pkg::QUEUE_DEPTH];
	logic [smh_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [smh_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [smh_pkg::QCNT_W-1:0]      count_q;
	smh_pkg::instr_t                 dec;
	smh_pkg::opcode_t                opcode;
	logic                            accept;

	assign s_axis_tready = (count_q != QFULL);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign opcode        = smh_pkg::opcode_t'(s_axis_tdata[2:0]);

	always_comb begin
		dec.immediate = s_axis_tdata[34:3];
		dec.last      = s_axis_tlast;
		dec.alu_op    = smh_pkg::ALU_ADD;
		unique case (opcode)
			smh_pkg::OP_PUSH:     dec.iclass = smh_pkg::CL_PUSH_IMM;
			smh_pkg::OP_ADD:      dec.iclass = smh_pkg::CL_BINARY;
			smh_pkg::OP_SHL: begin
				dec.iclass = smh_pkg::CL_BINARY;
				dec.alu_op = smh_pkg::ALU_SHL;
			end
			smh_pkg::OP_SHR: begin
				dec.iclass = smh_pkg::CL_BINARY;
				dec.alu_op = smh_pkg::ALU_SHR;
			end
			smh_pkg::OP_XOR: begin
				dec.iclass = smh_pkg::CL_BINARY;
				dec.alu_op = smh_pkg::ALU_XOR;
			end
			smh_pkg::OP_TO_MEM:   dec.iclass = smh_pkg::CL_TO_MEM;
			smh_pkg::OP_PUSH_MEM: dec.iclass = smh_pkg::CL_PUSH_MEM;
			default:              dec.iclass = smh_pkg::CL_BAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !accept) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.instr = q_mem_q[rd_ptr_q];

endmodule

@@ hdl/smh_back.sv @@
// Back end: executes queued instructions against the stack and drives the result word.
module smh_back #(
	parameter int unsigned STACK_DEPTH = smh_pkg::STACK_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  smh_pkg::q_head_t                 head,
	output logic                             pop,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [smh_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned W  = smh_pkg::WORD_W;
	localparam logic [DW-1:0] DEPTH_MAX = DW'(STACK_DEPTH);
	localparam logic [DW-1:0] DEPTH_TWO = DW'(2);

	typedef enum logic {
		S_RUN,
		S_OPER
	} state_t;

	// The top of stack lives in top_q; entries below it live in the RAM.
	logic [W-1:0]                 stack_mem [STACK_DEPTH];
	logic [W-1:0]                 rd_q;
	logic [W-1:0]                 top_q;
	logic [W-1:0]                 mem_q;
	logic [DW-1:0]                depth_q;
	logic                         halted_q;
	state_t                       state_q;
	logic                         m_valid_q;
	logic [smh_pkg::M_TDATA_W-1:0] m_data_q;

	logic                         can_out;
	logic                         commit;
	logic                         wr_en;
	logic                         rd_en;
	logic [DW-1:0]                dm1;
	logic [DW-1:0]                dm2;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                rd_addr;
	smh_pkg::status_t             status;
	logic [W-1:0]                 top_n;
	logic [W-1:0]                 mem_n;
	logic [DW-1:0]                depth_n;
	state_t                       state_n;
	logic [W-1:0]                 alu_res;
	logic [W-1:0]                 top_out;
	logic [DW+smh_pkg::DEPTH_OUT_W-1:0] depth_ext;

	assign can_out = !m_valid_q || m_axis_tready;
	assign dm1     = depth_q - 1'b1;
	assign dm2     = depth_q - DEPTH_TWO;
	assign wr_addr = dm1[AW-1:0];
	assign rd_addr = dm2[AW-1:0];

	// rd_q is the left operand, top_q the right one.
	always_comb begin
		unique case (head.instr.alu_op)
			smh_pkg::ALU_ADD: alu_res = rd_q + top_q;
			smh_pkg::ALU_SHL: alu_res = (|top_q[W-1:5]) ? '0 : (rd_q << top_q[4:0]);
			smh_pkg::ALU_SHR: alu_res = (|top_q[W-1:5]) ? '0 : (rd_q >> top_q[4:0]);
			default:          alu_res = rd_q ^ top_q;
		endcase
	end

	always_comb begin
		commit  = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		status  = smh_pkg::ST_OK;
		top_n   = top_q;
		mem_n   = mem_q;
		depth_n = depth_q;
		state_n = state_q;
		unique case (state_q)
			S_RUN: begin
				if (head.valid) begin
					if (halted_q) begin
						status = smh_pkg::ST_SKIP;
						commit = can_out;
					end else begin
						unique case (head.instr.iclass)
							smh_pkg::CL_PUSH_IMM, smh_pkg::CL_PUSH_MEM: begin
								commit = can_out;
								if (depth_q == DEPTH_MAX) begin
									status = smh_pkg::ST_OVERFLOW;
								end else begin
									top_n   = (head.instr.iclass == smh_pkg::CL_PUSH_IMM) ?
										head.instr.immediate : mem_q;
									depth_n = depth_q + 1'b1;
									wr_en   = can_out && (depth_q != '0);
								end
							end
							smh_pkg::CL_BINARY: begin
								if (depth_q < DEPTH_TWO) begin
									status = smh_pkg::ST_FEW;
									commit = can_out;
								end else begin
									rd_en   = 1'b1;
									state_n = S_OPER;
								end
							end
							smh_pkg::CL_TO_MEM: begin
								commit = can_out;
								if (depth_q == '0) begin
									status = smh_pkg::ST_FEW;
								end else begin
									mem_n = top_q;
								end
							end
							default: begin
								status = smh_pkg::ST_BADOP;
								commit = can_out;
							end
						endcase
					end
				end
			end
			S_OPER: begin
				top_n   = alu_res;
				depth_n = dm1;
				commit  = can_out;
				if (can_out) begin
					state_n = S_RUN;
				end
			end
			default: begin
				state_n = S_RUN;
			end
		endcase
	end

	assign pop       = commit;
	assign top_out   = (depth_n == '0) ? '0 : top_n;
	assign depth_ext = {{smh_pkg::DEPTH_OUT_W{1'b0}}, depth_n};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= top_q;
		end
		if (rd_en) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_RUN;
			top_q     <= '0;
			mem_q     <= '0;
			depth_q   <= '0;
			halted_q  <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			state_q <= state_n;
			if (commit) begin
				top_q     <= top_n;
				mem_q     <= mem_n;
				depth_q   <= depth_n;
				halted_q  <= head.instr.last ? 1'b0 :
					(halted_q || (status != smh_pkg::ST_OK));
				m_valid_q <= 1'b1;
				m_data_q  <= {mem_n, depth_ext[smh_pkg::DEPTH_OUT_W-1:0], top_out, status};
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

@@ hdl/stack_machine_hash_alu.sv @@
// Top level of the stack machine ALU: front end, instruction queue and executor.
//
// Each input word carries one instruction (opcode, push immediate, end-of-program mark)
// and produces exactly one result word with the status, the new top of stack (zero when
// empty), the stack depth and the memory register. A two-word queue in the front end
// decouples the input from execution, and the result sits in an output register, so a
// stalled consumer does not stop input until the queue fills. Push, push-memory,
// top-to-memory, errors and skipped words complete from the run state; add, shifts and
// xor also pass through an operand state, because the left operand is fetched from the
// stack RAM through its registered read port while the top of stack is held in a
// register. The stack RAM needs no clearing after reset, and the block is ready out of reset.
module stack_machine_hash_alu #(
	parameter int unsigned STACK_DEPTH = smh_pkg::STACK_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// Fields from bit 0: opcode[2:0], immediate[34:3], zero fill[39:35].
	input  logic [smh_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// Fields from bit 0: status[2:0], top_value[34:3], stack_depth[39:35], mem_value[71:40].
	output logic [smh_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

`include "stack_machine_hash_alu_macros.svh"

	smh_pkg::q_head_t head;
	logic             pop;

	smh_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.head          (head),
		.pop           (pop)
	);

	smh_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	`SMH_ASSERT_IMPL(a_pop_needs_head, pop, head.valid, "Executor popped an empty queue")
	`SMH_ASSERT_IMPL(a_full_means_pending, !s_axis_tready, head.valid, "Full queue shows no head")
	`SMH_ASSERT_IMPL(a_status_range, m_axis_tvalid, m_axis_tdata[2:0] <= smh_pkg::ST_SKIP, "Result status out of range")
	`SMH_ASSERT_IMPL(a_empty_top_zero, m_axis_tvalid && (STACK_DEPTH < 32) && (m_axis_tdata[39:35] == 5'd0), m_axis_tdata[34:3] == 32'd0, "Empty stack shows a nonzero top")
	`SMH_ASSERT_NEXT(a_pop_gives_result, pop, m_axis_tvalid, "Executed instruction gave no result")

endmodule
